// ----- src/psnd_pkg.sv -----
`timescale 1ns / 1ps

package psnd_pkg;

	// Default sizing of the reference store and the coordinate datapath
	localparam int MAX_REF_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF     = 16;

	// Fixed field widths of the channels
	localparam int IN_COORD_W = 16;
	localparam int MIN_W      = 34;
	localparam int SUM_W      = 63;

	// Entries in the command queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Operation codes on the request channel
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Command kinds that the front hands to the back
	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                     kind;
		logic signed [IN_COORD_W-1:0]  x;
		logic signed [IN_COORD_W-1:0]  y;
		logic signed [IN_COORD_W-1:0]  z;
		logic                          last;
	} cmd_t;

endpackage

// ----- src/psnd_if.sv -----
`timescale 1ns / 1ps

// Request channel: load, query or clear, with one point
interface psnd_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             operation;
	logic signed [psnd_pkg::IN_COORD_W-1:0] x_coord;
	logic signed [psnd_pkg::IN_COORD_W-1:0] y_coord;
	logic signed [psnd_pkg::IN_COORD_W-1:0] z_coord;
	logic                                   last_query;

	modport source (output valid, operation, x_coord, y_coord, z_coord, last_query,
		input ready);
	modport sink (input valid, operation, x_coord, y_coord, z_coord, last_query,
		output ready);
endinterface

// Response channel: one result per query
interface psnd_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [psnd_pkg::MIN_W-1:0]  min_dist_sq;
	logic [psnd_pkg::SUM_W-1:0]  running_sum;
	logic                        empty_ref;
	logic                        set_done;

	modport source (output valid, min_dist_sq, running_sum, empty_ref, set_done,
		input ready);
	modport sink (input valid, min_dist_sq, running_sum, empty_ref, set_done,
		output ready);
endinterface

// Configuration write channel for the use_z register
interface psnd_cfg_if;
	logic valid;
	logic ready;
	logic use_z;

	modport source (output valid, use_z, input ready);
	modport sink (input valid, use_z, output ready);
endinterface

// ----- src/psnd_front.sv -----
`timescale 1ns / 1ps

module psnd_front (
	psnd_req_if.sink          req,
	output logic              push_valid,
	output psnd_pkg::cmd_t    push_data,
	input  logic              push_ready
);
	import psnd_pkg::*;

	op_t op;

	assign op = op_t'(req.operation);

	// Take a request whenever the queue has room; unused codes are dropped here
	assign req.ready  = push_ready;
	assign push_valid = req.valid && (op != OP_NONE);

	// Classify the request into a back-end command
	always_comb begin
		push_data.x    = req.x_coord;
		push_data.y    = req.y_coord;
		push_data.z    = req.z_coord;
		push_data.last = 1'b0;
		unique case (op)
			OP_LOAD:  push_data.kind = CMD_LOAD;
			OP_QUERY: begin
				push_data.kind = CMD_QUERY;
				push_data.last = req.last_query;
			end
			OP_CLEAR: push_data.kind = CMD_CLEAR;
			default:  push_data.kind = CMD_CLEAR;
		endcase
	end

endmodule

// ----- src/psnd_queue.sv -----
`timescale 1ns / 1ps

module psnd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  psnd_pkg::cmd_t    push_data,
	output logic              push_ready,
	output logic              pop_valid,
	output psnd_pkg::cmd_t    pop_data,
	input  logic              pop_ready
);
	import psnd_pkg::*;

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	cmd_t           entry_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] fill_q;
	logic           push_fire;
	logic           pop_fire;

	assign push_ready = (fill_q != QCW'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	// Store the pushed command
	always_ff @(posedge clk) begin
		if (push_fire) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/psnd_back.sv -----
`timescale 1ns / 1ps

module psnd_back #(
	parameter int MAX_REF_POINTS = psnd_pkg::MAX_REF_POINTS_DEF,
	parameter int COORD_BITS     = psnd_pkg::COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	input  psnd_pkg::cmd_t    pop_data,
	output logic              pop_ready,
	psnd_cfg_if.sink          cfg,
	psnd_rsp_if.source        rsp
);
	import psnd_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int AW  = (MAX_REF_POINTS > 1) ? $clog2(MAX_REF_POINTS) : 1;
	localparam int CW  = $clog2(MAX_REF_POINTS + 1);
	localparam int SQW = 2 * (CB + 1);
	localparam int DW  = SQW + 2;
	localparam int BW  = (DW > MIN_W) ? DW : MIN_W;

	localparam logic [MIN_W-1:0] MIN_MAX = '1;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;

	logic [3*CB-1:0]       ref_mem [MAX_REF_POINTS];
	logic [CW-1:0]         count_q;
	logic [SUM_W-1:0]      total_q;
	logic                  use_z_q;

	logic signed [CB-1:0]  q_x_q;
	logic signed [CB-1:0]  q_y_q;
	logic signed [CB-1:0]  q_z_q;
	logic                  q_last_q;
	logic                  q_empty_q;

	logic [CW-1:0]         scan_idx_q;
	logic                  issue;
	logic                  mem_we;
	logic                  pop_fire;

	logic [3*CB-1:0]       rd_s1;
	logic                  v_s1;
	logic [SQW-1:0]        sq_x_s2;
	logic [SQW-1:0]        sq_y_s2;
	logic [SQW-1:0]        sq_z_s2;
	logic                  v_s2;
	logic [DW-1:0]         dist_s3;
	logic                  v_s3;
	logic [DW-1:0]         best_q;
	logic                  first_q;

	logic signed [CB-1:0]  rd_x;
	logic signed [CB-1:0]  rd_y;
	logic signed [CB-1:0]  rd_z;
	logic signed [CB:0]    dx;
	logic signed [CB:0]    dy;
	logic signed [CB:0]    dz;
	logic [CB:0]           mx;
	logic [CB:0]           my;
	logic [CB:0]           mz;

	logic [BW-1:0]         best_ext;
	logic [MIN_W-1:0]      min_sat;
	logic [SUM_W:0]        sum_raw;
	logic [SUM_W-1:0]      sum_new;
	logic                  out_free;

	// Configuration register, always writable
	assign cfg.ready = 1'b1;

	assign pop_ready = (state_q == S_IDLE);
	assign pop_fire  = pop_valid && pop_ready;
	assign mem_we    = pop_fire && (pop_data.kind == CMD_LOAD) &&
		(count_q != CW'(MAX_REF_POINTS));
	assign issue     = (state_q == S_SCAN) && (scan_idx_q < count_q);

	// Reference store: one write port for loads, one read port for the scan
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ref_mem[count_q[AW-1:0]] <= {CB'(pop_data.z), CB'(pop_data.y), CB'(pop_data.x)};
		end
		if (issue) begin
			rd_s1 <= ref_mem[scan_idx_q[AW-1:0]];
		end
	end

	// Differences and magnitudes of the fetched point against the query
	assign rd_x = rd_s1[CB-1:0];
	assign rd_y = rd_s1[2*CB-1:CB];
	assign rd_z = rd_s1[3*CB-1:2*CB];
	assign dx   = (CB+1)'(rd_x) - (CB+1)'(q_x_q);
	assign dy   = (CB+1)'(rd_y) - (CB+1)'(q_y_q);
	assign dz   = (CB+1)'(rd_z) - (CB+1)'(q_z_q);
	assign mx   = dx[CB] ? (CB+1)'(-dx) : dx;
	assign my   = dy[CB] ? (CB+1)'(-dy) : dy;
	assign mz   = dz[CB] ? (CB+1)'(-dz) : dz;

	// Square, then sum, one register each
	always_ff @(posedge clk) begin
		sq_x_s2 <= SQW'(mx) * SQW'(mx);
		sq_y_s2 <= SQW'(my) * SQW'(my);
		sq_z_s2 <= use_z_q ? SQW'(mz) * SQW'(mz) : '0;
		dist_s3 <= DW'(sq_x_s2) + DW'(sq_y_s2) + DW'(sq_z_s2);
	end

	// Saturate the minimum and add it to the running sum
	assign best_ext = BW'(best_q);
	assign min_sat  = (best_ext > BW'(MIN_MAX)) ? MIN_MAX : best_ext[MIN_W-1:0];
	assign sum_raw  = {1'b0, total_q} + (SUM_W+1)'(min_sat);
	assign sum_new  = sum_raw[SUM_W] ? SUM_MAX : sum_raw[SUM_W-1:0];
	assign out_free = !rsp.valid || rsp.ready;

	// Hold the result in the output register
	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			rsp.min_dist_sq <= q_empty_q ? '0 : min_sat;
			rsp.running_sum <= q_empty_q ? total_q : sum_new;
			rsp.empty_ref   <= q_empty_q;
			rsp.set_done    <= q_last_q;
		end
	end

	// Latch the query point at pop
	always_ff @(posedge clk) begin
		if (pop_fire && (pop_data.kind == CMD_QUERY)) begin
			q_x_q    <= CB'(pop_data.x);
			q_y_q    <= CB'(pop_data.y);
			q_z_q    <= CB'(pop_data.z);
			q_last_q <= pop_data.last;
		end
	end

	// Control: sequencer, counters, scan pipeline valids, sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			total_q    <= '0;
			use_z_q    <= 1'b1;
			scan_idx_q <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			first_q    <= 1'b0;
			best_q     <= '0;
			q_empty_q  <= 1'b0;
			rsp.valid  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				use_z_q <= cfg.use_z;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (v_s3) begin
				first_q <= 1'b0;
				if (first_q || (dist_s3 < best_q)) begin
					best_q <= dist_s3;
				end
			end
			// Raise valid when a result lands, drop it after the transfer
			if ((state_q == S_DONE) && out_free) begin
				rsp.valid <= 1'b1;
			end else if (rsp.ready) begin
				rsp.valid <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (pop_fire) begin
						unique case (pop_data.kind)
							CMD_LOAD: begin
								if (mem_we) begin
									count_q <= count_q + 1'b1;
								end
							end
							CMD_QUERY: begin
								scan_idx_q <= '0;
								first_q    <= 1'b1;
								q_empty_q  <= (count_q == '0);
								state_q    <= (count_q == '0) ? S_DONE : S_SCAN;
							end
							CMD_CLEAR: begin
								count_q <= '0;
								total_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					// Leave once all addresses are issued and the pipeline drained
					if (!issue && !v_s1 && !v_s2 && !v_s3) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						if (q_last_q) begin
							total_q <= '0;
						end else if (!q_empty_q) begin
							total_q <= sum_new;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- src/point_set_nearest_distance_sum.sv -----
`timescale 1ns / 1ps

// Directed nearest-distance sum over a reference point set.
// Channel req carries load, query and clear requests with one point each;
// an unused operation code is taken and dropped. Channel rsp returns one
// result per query: the minimum squared distance to the stored points, the
// running sum of minima in the current set (saturating), an empty-store
// flag and the set-done mark, after which the sum restarts at zero.
// Channel cfg writes use_z (1 = 3D, 0 = 2D) at any cycle with valid high.
// A front stage classifies requests into a four-entry command queue; the
// back end runs them in order. A load or clear leaves the back end free for the next command.
// A query scans the store one reference point per cycle through a single
// memory read port; the read, square and sum registers lead to the result
// register, and the back end takes no new command before the result is in it.
// Reset empties the store by zeroing its fill count (no clearing pass),
// zeroes the sum and sets use_z to 1. When rsp stalls, the finished result
// holds in its register; the back end goes on with loads and clears and
// the next query scans but waits for the register before it completes.
// The front keeps taking requests while the queue has room.
module point_set_nearest_distance_sum #(
	parameter int MAX_REF_POINTS = psnd_pkg::MAX_REF_POINTS_DEF,
	parameter int COORD_BITS     = psnd_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	psnd_req_if.sink    req,
	psnd_cfg_if.sink    cfg,
	psnd_rsp_if.source  rsp
);
	import psnd_pkg::*;

	logic push_valid;
	cmd_t push_data;
	logic push_ready;
	logic pop_valid;
	cmd_t pop_data;
	logic pop_ready;

	psnd_front u_front (
		.req        (req),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	psnd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	psnd_back #(
		.MAX_REF_POINTS (MAX_REF_POINTS),
		.COORD_BITS     (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.cfg       (cfg),
		.rsp       (rsp)
	);

	// An empty-store result reports zero distance
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.empty_ref |-> rsp.min_dist_sq == '0)
		else $error("empty-store result with nonzero distance");

	// The running sum always covers the minimum it includes
	a_sum_covers_min: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.empty_ref |-> rsp.running_sum >= SUM_W'(rsp.min_dist_sq))
		else $error("running sum below its own minimum");

	// An unused operation never reaches the queue
	a_drop_unused: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && (req.operation == OP_NONE) |-> !push_valid)
		else $error("unused operation pushed to queue");

	// With the back end idle and no command queued, a held result changes only after a transfer
	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ready && !pop_valid |=> !rsp.valid || $stable(rsp.running_sum) || $past(rsp.ready))
		else $error("result changed without a command or a transfer");

endmodule

// ----- dv/point_set_nearest_distance_sum_tb.sv -----
`timescale 1ns / 1ps

module point_set_nearest_distance_sum_tb;
	import psnd_pkg::*;

	localparam int MAX_REFS = MAX_REF_POINTS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 700;
	localparam int TAIL_CYCLES = 64;
	localparam int SETTLE_CYCLES = 32;
	localparam int RANDOM_ITEMS = 580;
	localparam longint unsigned MIN_CAP = (64'd1 << MIN_W) - 64'd1;
	localparam longint unsigned SUM_CAP = (64'd1 << SUM_W) - 64'd1;

	typedef struct packed {
		op_t                          op;
		logic signed [IN_COORD_W-1:0] x;
		logic signed [IN_COORD_W-1:0] y;
		logic signed [IN_COORD_W-1:0] z;
		logic                         last;
	} point_req_t;

	typedef struct packed {
		logic [MIN_W-1:0] min_dist_sq;
		logic [SUM_W-1:0] running_sum;
		logic             empty_ref;
		logic             set_done;
	} nearest_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Bench-side copies of every block input, known from time zero
	logic       drv_valid = 1'b0;
	point_req_t drv_item = '0;
	logic       sink_ready = 1'b0;
	logic       cfg_valid_q = 1'b0;
	logic       cfg_bit_q = 1'b1;

	psnd_req_if req_ch ();
	psnd_rsp_if rsp_ch ();
	psnd_cfg_if cfg_ch ();

	assign req_ch.valid      = drv_valid;
	assign req_ch.operation  = drv_item.op;
	assign req_ch.x_coord    = drv_item.x;
	assign req_ch.y_coord    = drv_item.y;
	assign req_ch.z_coord    = drv_item.z;
	assign req_ch.last_query = drv_item.last;
	assign rsp_ch.ready      = sink_ready;
	assign cfg_ch.valid      = cfg_valid_q;
	assign cfg_ch.use_z      = cfg_bit_q;

	point_set_nearest_distance_sum u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.cfg    (cfg_ch),
		.rsp    (rsp_ch)
	);

	always #4 clk = ~clk;

	// Shadow of the block state
	logic signed [IN_COORD_W-1:0] ref_x [MAX_REFS];
	logic signed [IN_COORD_W-1:0] ref_y [MAX_REFS];
	logic signed [IN_COORD_W-1:0] ref_z [MAX_REFS];
	int              ref_fill = 0;
	longint unsigned chamfer_sum = 0;
	bit              use_z_now = 1'b1;

	point_req_t pending[$];
	nearest_t   minima_due[$];

	bit calm = 1'b0;
	bit hold_arm = 1'b0;
	int hold_left = 0;
	bit hold_used = 1'b0;
	int cycle_count = 0;

	int mismatches = 0;
	int results_seen = 0;
	int n_queries = 0;
	int n_empty = 0;
	int n_flat = 0;
	int n_sets = 0;
	int n_stored = 0;
	int n_dropped = 0;
	int store_est = 0;
	int rand_items = 0;
	bit count_items = 1'b0;

	task automatic flag_mismatch(input string what, input longint unsigned got,
		input longint unsigned want);
		mismatches++;
		$display("MISMATCH %s at result %0d: got %0d, expected %0d", what, results_seen, got,
			want);
	endtask

	function automatic longint unsigned point_gap(input point_req_t q, input int j);
		longint dx;
		longint dy;
		longint dz;
		longint unsigned t;
		dx = longint'(q.x) - longint'(ref_x[j]);
		dy = longint'(q.y) - longint'(ref_y[j]);
		dz = longint'(q.z) - longint'(ref_z[j]);
		t = longint'(dx * dx) + longint'(dy * dy);
		if (use_z_now)
			t += longint'(dz * dz);
		return t;
	endfunction

	// Advance the shadow state by one accepted request, queue the nearest result
	task automatic account_request(input point_req_t it);
		nearest_t        r;
		longint unsigned best;
		longint unsigned d;
		bit              empty;
		case (it.op)
			OP_LOAD: begin
				if (ref_fill < MAX_REFS) begin
					ref_x[ref_fill] = it.x;
					ref_y[ref_fill] = it.y;
					ref_z[ref_fill] = it.z;
					ref_fill++;
					n_stored++;
				end else begin
					n_dropped++;
				end
			end
			OP_CLEAR: begin
				ref_fill = 0;
				chamfer_sum = 0;
			end
			OP_QUERY: begin
				empty = (ref_fill == 0);
				best = 0;
				if (!empty) begin
					for (int j = 0; j < ref_fill; j++) begin
						d = point_gap(it, j);
						if (j == 0 || d < best)
							best = d;
					end
					if (best > MIN_CAP)
						best = MIN_CAP;
					if (chamfer_sum > SUM_CAP - best)
						chamfer_sum = SUM_CAP;
					else
						chamfer_sum += best;
				end
				r.min_dist_sq = best[MIN_W-1:0];
				r.running_sum = chamfer_sum[SUM_W-1:0];
				r.empty_ref   = empty;
				r.set_done    = it.last;
				minima_due.push_back(r);
				n_queries++;
				if (empty)
					n_empty++;
				if (!use_z_now)
					n_flat++;
				if (it.last) begin
					chamfer_sum = 0;
					n_sets++;
				end
			end
			default: ;
		endcase
	endtask

	// Driver: offer pending requests, idle at random when free
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_item  <= '0;
		end else begin
			if (drv_valid && req_ch.ready)
				account_request(drv_item);
			if (!drv_valid || req_ch.ready) begin
				if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 19)) begin
					drv_item  <= pending.pop_front();
					drv_valid <= 1'b1;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, armed once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end
	end

	// Monitor: compare each result transfer with the oldest expected minimum
	always @(posedge clk or negedge arst_n) begin : watch_results
		nearest_t want;
		if (!arst_n) begin
			sink_ready <= 1'b0;
		end else begin
			if (rsp_ch.valid === 1'b1 && sink_ready) begin
				results_seen++;
				if (minima_due.size() == 0) begin
					flag_mismatch("unexpected result", rsp_ch.min_dist_sq, 0);
				end else begin
					want = minima_due.pop_front();
					if (rsp_ch.min_dist_sq !== want.min_dist_sq)
						flag_mismatch("min_dist_sq", rsp_ch.min_dist_sq, want.min_dist_sq);
					if (rsp_ch.running_sum !== want.running_sum)
						flag_mismatch("running_sum", rsp_ch.running_sum, want.running_sum);
					if (rsp_ch.empty_ref !== want.empty_ref)
						flag_mismatch("empty_ref", rsp_ch.empty_ref, want.empty_ref);
					if (rsp_ch.set_done !== want.set_done)
						flag_mismatch("set_done", rsp_ch.set_done, want.set_done);
				end
			end
			sink_ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 19);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				minima_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic queue_request(input op_t op, input logic signed [IN_COORD_W-1:0] x,
		input logic signed [IN_COORD_W-1:0] y, input logic signed [IN_COORD_W-1:0] z,
		input bit last);
		point_req_t it;
		it.op   = op;
		it.x    = x;
		it.y    = y;
		it.z    = z;
		it.last = last;
		pending.push_back(it);
		if (op == OP_LOAD && store_est < MAX_REFS)
			store_est++;
		if (op == OP_CLEAR)
			store_est = 0;
		if (count_items && op != OP_NONE)
			rand_items++;
	endtask

	function automatic logic signed [IN_COORD_W-1:0] pick_coord();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return IN_COORD_W'($urandom_range(0, 16) - 8);
			default: return IN_COORD_W'($urandom);
		endcase
	endfunction

	// Hold until every request is taken and every result has come back
	task automatic drain();
		@(negedge clk);
		while (pending.size() != 0 || drv_valid || minima_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_use_z(input bit v);
		@(posedge clk);
		cfg_valid_q <= 1'b1;
		cfg_bit_q   <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_valid_q <= 1'b0;
		use_z_now = v;
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic signed [IN_COORD_W-1:0] px[$];
		logic signed [IN_COORD_W-1:0] py[$];
		logic signed [IN_COORD_W-1:0] pz[$];
		logic signed [IN_COORD_W-1:0] qx;
		logic signed [IN_COORD_W-1:0] qy;
		logic signed [IN_COORD_W-1:0] qz;
		int  phase;
		int  nref;
		int  nqry;
		int  k;
		bit  cap_done;
		bit  well_formed;
		bit  start_clear;

		phase = 0;
		cap_done = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(negedge clk);
		write_use_z(1'b1);

		// Empty store: flagged, the second query still closes the set
		queue_request(OP_QUERY, 16'sd100, -16'sd100, 16'sd5, 1'b0);
		queue_request(OP_QUERY, -16'sd32768, 16'sd32767, 16'sd0, 1'b1);
		// Unused code is dropped
		queue_request(OP_NONE, 16'sd32767, -16'sd1, -16'sd32768, 1'b1);
		// Farthest corners give the largest distance
		queue_request(OP_LOAD, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
		queue_request(OP_QUERY, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
		// Last mark on a load is ignored
		queue_request(OP_LOAD, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1);
		queue_request(OP_QUERY, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
		queue_request(OP_QUERY, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0);
		queue_request(OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		queue_request(OP_QUERY, -16'sd1, -16'sd1, -16'sd1, 1'b1);
		queue_request(OP_LOAD, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		queue_request(OP_QUERY, 16'sd1, -16'sd1, 16'sd2, 1'b0);
		queue_request(OP_QUERY, -16'sd32768, 16'sd32767, -16'sd32768, 1'b1);
		// Clear with a last mark, then the store reads as empty
		queue_request(OP_CLEAR, -16'sd1, -16'sd1, -16'sd1, 1'b1);
		queue_request(OP_QUERY, 16'sd7, 16'sd7, 16'sd7, 1'b1);
		queue_request(OP_LOAD, 16'sd12, -16'sd12, 16'sd32767, 1'b0);
		queue_request(OP_QUERY, 16'sd12, -16'sd12, -16'sd32768, 1'b0);
		drain();
		// 2D: z no longer counts, sum carries over from the open set
		write_use_z(1'b0);
		queue_request(OP_QUERY, 16'sd12, -16'sd12, -16'sd32768, 1'b0);
		queue_request(OP_QUERY, -16'sd32768, 16'sd32767, 16'sd0, 1'b1);
		queue_request(OP_CLEAR, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		queue_request(OP_QUERY, 16'sd3, 16'sd3, 16'sd3, 1'b1);
		drain();
		write_use_z(1'b1);

		// Random phases: mostly well-formed sets, some noise
		count_items = 1'b1;
		while (rand_items < RANDOM_ITEMS) begin
			drain();
			if ($urandom_range(0, 1))
				write_use_z($urandom_range(0, 1));
			phase++;
			calm = (rand_items >= 200 && rand_items < 300);
			well_formed = 1'b1;
			start_clear = (store_est > 48) || ($urandom_range(0, 9) != 0);
			nref = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
			nqry = $urandom_range(1, 8);
			if (phase == 2) begin
				// Receiver holds off while the sender keeps offering
				hold_arm = 1'b1;
				start_clear = 1'b1;
				nref = 3;
				nqry = 40;
			end else if (!cap_done && rand_items >= 300) begin
				// Fill the store past capacity, then scan it whole
				cap_done = 1'b1;
				count_items = 1'b0;
				start_clear = 1'b1;
				nref = MAX_REFS + 6;
				nqry = 3;
			end else if ($urandom_range(0, 99) >= 80) begin
				well_formed = 1'b0;
			end

			if (well_formed) begin
				px.delete();
				py.delete();
				pz.delete();
				if (start_clear)
					queue_request(OP_CLEAR, pick_coord(), pick_coord(), pick_coord(),
						$urandom_range(0, 1));
				for (int i = 0; i < nref; i++) begin
					qx = pick_coord();
					qy = pick_coord();
					qz = pick_coord();
					queue_request(OP_LOAD, qx, qy, qz, $urandom_range(0, 9) == 0);
					px.push_back(qx);
					py.push_back(qy);
					pz.push_back(qz);
				end
				for (int i = 0; i < nqry; i++) begin
					if ($urandom_range(0, 9) == 0) begin
						qx = pick_coord();
						qy = pick_coord();
						qz = pick_coord();
						queue_request(OP_LOAD, qx, qy, qz, 1'b0);
						px.push_back(qx);
						py.push_back(qy);
						pz.push_back(qz);
					end
					if (px.size() != 0 && $urandom_range(0, 1)) begin
						k = $urandom_range(0, px.size() - 1);
						qx = px[k] + IN_COORD_W'($urandom_range(0, 16) - 8);
						qy = py[k] + IN_COORD_W'($urandom_range(0, 16) - 8);
						qz = pz[k] + IN_COORD_W'($urandom_range(0, 16) - 8);
					end else begin
						qx = pick_coord();
						qy = pick_coord();
						qz = pick_coord();
					end
					queue_request(OP_QUERY, qx, qy, qz, i == nqry - 1);
				end
				count_items = 1'b1;
			end else begin
				for (int i = 0; i < 6; i++)
					queue_request(op_t'($urandom_range(0, 3)), pick_coord(), pick_coord(),
						pick_coord(), $urandom_range(0, 1));
			end
		end
		calm = 1'b0;

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("covered %0d queries over %0d closed sets, %0d on an empty store, %0d in 2D",
			n_queries, n_sets, n_empty, n_flat);
		$display("stored %0d points, dropped %0d loads at capacity, checked %0d results",
			n_stored, n_dropped, results_seen);
		if (mismatches == 0 && minima_due.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/psnd_pkg.sv
src/psnd_if.sv
src/psnd_front.sv
src/psnd_queue.sv
src/psnd_back.sv
src/point_set_nearest_distance_sum.sv
dv/point_set_nearest_distance_sum_tb.sv
